FILE: design/masm_pkg.sv
// Shared types, codes and helpers for the matrix add/subtract/multiply unit.
// Used by masm_ctrl, masm_datapath and matrix_add_sub_mul_unit; no dependencies.
package masm_pkg;

    localparam int DIM_DEFAULT = 8;
    localparam logic [3:0] COUNT_RESET = 4'd8;

    localparam logic [2:0] FUNC_WRITE_A = 3'd0;
    localparam logic [2:0] FUNC_WRITE_B = 3'd1;
    localparam logic [2:0] FUNC_ADD     = 3'd2;
    localparam logic [2:0] FUNC_SUB     = 3'd3;
    localparam logic [2:0] FUNC_MUL     = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_FUNC = 2'd1;
    localparam logic [1:0] STATUS_SHAPE    = 2'd2;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]         func;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] elem_value;
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic [1:0]         status;
        logic               last;
    } result_t;

    // One issued step of a command, from the controller to the datapath.
    typedef struct packed {
        logic       valid;
        logic       mul;
        logic       sub;
        logic       first;
        logic       emit;
        logic       last;
        logic [1:0] status;
        logic [2:0] a_row;
        logic [2:0] a_col;
        logic [2:0] b_row;
        logic [2:0] b_col;
        logic [2:0] out_row;
        logic [2:0] out_col;
    } cmd_t;

    typedef struct packed {
        logic we_a;
        logic we_b;
    } load_t;

    // Clamps a configured count to 1..dim and returns the count minus one.
    function automatic logic [2:0] count_m1(input logic [3:0] cnt, input int dim);
        logic [3:0] eff;
        eff = cnt;
        if (cnt == 4'd0)
        begin
            eff = 4'd1;
        end
        else if (cnt > 4'(dim))
        begin
            eff = 4'(dim);
        end
        return 3'(eff - 4'd1);
    endfunction

endpackage

FILE: design/matrix_add_sub_mul_unit.sv
// Top level of the integer matrix add/subtract/multiply unit.
// Depends on masm_pkg, masm_ctrl and masm_datapath.
//
//  Channel   Handshake               Word
//  -------   ---------------------   -------------------------------
//  item      start && !busy          func, row, col, value
//  result    result_valid (1 cycle)  elem_value, out_row, out_col,
//                                    status, last
//  config    cfg_valid && cfg_ready  cfg_index (0 rows, 1 cols), cfg_data
//
// A load word gives no result. Add and subtract issue one element a cycle;
// multiply issues one dot-product term a cycle through the single read port
// of each store. Results pass the store read registers, the sum or product
// register and the result register; error words take the same path.
// Reset restores both counts to 8; store contents are not cleared.
// The receiver cannot stall, so result_valid never waits on anything.
module matrix_add_sub_mul_unit
    import masm_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    output logic       result_valid,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    load_t load;
    cmd_t  cmd;

    assign cfg_ready = 1'b1;

    masm_ctrl #(
        .DIM(DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load      (load),
        .cmd       (cmd)
    );

    masm_datapath #(
        .DIM(DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .load         (load),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: design/masm_ctrl.sv
// Controller: configuration registers, item decode and the element/term sweep.
// Depends on masm_pkg; drives the command stream into masm_datapath.
module masm_ctrl
    import masm_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    output logic       busy,
    input  logic       cfg_valid,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    output load_t      load,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] row_count_reg, col_count_reg;
    logic [2:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic       mul_reg, mul_next, sub_reg, sub_next;
    cmd_t       cmd_reg, cmd_next;
    logic [2:0] rows_m1, cols_m1;
    logic       accept, term_done;

    assign rows_m1 = count_m1(row_count_reg, DIM);
    assign cols_m1 = count_m1(col_count_reg, DIM);
    assign busy    = (state_reg == ST_RUN);
    assign accept  = start && !busy;
    assign cmd     = cmd_reg;

    // Writes into a store complete at the accepting edge.
    assign load.we_a = accept && (item.func == FUNC_WRITE_A);
    assign load.we_b = accept && (item.func == FUNC_WRITE_B);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= COUNT_RESET;
            col_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else
            begin
                col_count_reg <= cfg_data;
            end
        end
    end

    assign term_done = !mul_reg || (k_reg == cols_m1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        mul_next   = mul_reg;
        sub_next   = sub_reg;
        cmd_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.func)
                        FUNC_WRITE_A, FUNC_WRITE_B:
                        begin
                            cmd_next = '0;
                        end
                        FUNC_ADD, FUNC_SUB, FUNC_MUL:
                        begin
                            if ((item.func == FUNC_MUL) && (rows_m1 != cols_m1))
                            begin
                                cmd_next.valid  = 1'b1;
                                cmd_next.emit   = 1'b1;
                                cmd_next.last   = 1'b1;
                                cmd_next.status = STATUS_SHAPE;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                                i_next     = 3'd0;
                                j_next     = 3'd0;
                                k_next     = 3'd0;
                                mul_next   = (item.func == FUNC_MUL);
                                sub_next   = (item.func == FUNC_SUB);
                            end
                        end
                        default:
                        begin
                            cmd_next.valid  = 1'b1;
                            cmd_next.emit   = 1'b1;
                            cmd_next.last   = 1'b1;
                            cmd_next.status = STATUS_BAD_FUNC;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd_next.valid   = 1'b1;
                cmd_next.mul     = mul_reg;
                cmd_next.sub     = sub_reg;
                cmd_next.status  = STATUS_OK;
                cmd_next.first   = !mul_reg || (k_reg == 3'd0);
                cmd_next.emit    = term_done;
                cmd_next.last    = term_done && (i_reg == rows_m1) && (j_reg == cols_m1);
                cmd_next.a_row   = i_reg;
                cmd_next.a_col   = mul_reg ? k_reg : j_reg;
                cmd_next.b_row   = mul_reg ? k_reg : i_reg;
                cmd_next.b_col   = j_reg;
                cmd_next.out_row = i_reg;
                cmd_next.out_col = j_reg;
                if (term_done)
                begin
                    k_next = 3'd0;
                    if (j_reg == cols_m1)
                    begin
                        j_next = 3'd0;
                        if (i_reg == rows_m1)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 3'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
            i_reg     <= 3'd0;
            j_reg     <= 3'd0;
            k_reg     <= 3'd0;
            mul_reg   <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            mul_reg   <= mul_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

FILE: design/masm_datapath.sv
// Datapath: the A and B stores, add/subtract, multiply-accumulate, result register.
// Depends on masm_pkg; takes load and command words from masm_ctrl.
module masm_datapath
    import masm_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  load_t   load,
    input  cmd_t    cmd,
    output logic    result_valid,
    output result_t result
);

    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0]   mem_a [DEPTH];
    logic [31:0]   mem_b [DEPTH];
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic          wr_in_range;

    logic [31:0] rd_a_reg, rd_b_reg;
    logic [31:0] prod_reg, sum_reg, acc_reg;
    logic [31:0] acc_next;
    cmd_t        tag1_reg, tag2_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    assign wr_in_range = ({1'b0, item.row} < 4'(DIM)) && ({1'b0, item.col} < 4'(DIM));
    assign wr_addr   = AW'(int'(item.row) * DIM + int'(item.col));
    assign rd_addr_a = AW'(int'(cmd.a_row) * DIM + int'(cmd.a_col));
    assign rd_addr_b = AW'(int'(cmd.b_row) * DIM + int'(cmd.b_col));

    always_ff @(posedge clk)
    begin
        if (load.we_a && wr_in_range)
        begin
            mem_a[wr_addr] <= item.value;
        end
        if (load.we_b && wr_in_range)
        begin
            mem_b[wr_addr] <= item.value;
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
        prod_reg <= rd_a_reg * rd_b_reg;
        sum_reg  <= tag1_reg.sub ? (rd_a_reg - rd_b_reg) : (rd_a_reg + rd_b_reg);
        acc_reg  <= acc_next;
    end

    // The accumulator restarts on the first term of each dot product.
    assign acc_next = (tag2_reg.first ? 32'd0 : acc_reg) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg         <= '0;
            tag2_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg         <= cmd;
            tag2_reg         <= tag1_reg;
            result_valid_reg <= tag2_reg.valid && tag2_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag2_reg.status != STATUS_OK)
        begin
            result_reg.elem_value <= '0;
        end
        else if (tag2_reg.mul)
        begin
            result_reg.elem_value <= acc_next;
        end
        else
        begin
            result_reg.elem_value <= sum_reg;
        end
        result_reg.out_row <= tag2_reg.out_row;
        result_reg.out_col <= tag2_reg.out_col;
        result_reg.status  <= tag2_reg.status;
        result_reg.last    <= tag2_reg.last;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for matrix_add_sub_mul_unit: loads both stores, runs add,
// subtract and multiply words over several row and column counts, and checks every result.
// Depends on masm_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench
    import masm_pkg::*;
();

    localparam int MAT_DIM = DIM_DEFAULT;
    localparam int SETTLE_CYCLES = 10;
    localparam int WAIT_LIMIT = 20000;
    localparam int RANDOM_BLOCKS = 9;
    localparam int WORDS_PER_BLOCK = 25;

    // Function codes that the unit does not implement.
    localparam logic [2:0] FUNC_INVALID_LO  = 3'd5;
    localparam logic [2:0] FUNC_INVALID_MID = 3'd6;
    localparam logic [2:0] FUNC_INVALID_HI  = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    item_t      item;
    logic       result_valid;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [3:0] cfg_data;

    // Predicted state of the unit.
    logic [31:0] store_a [MAT_DIM*MAT_DIM];
    logic [31:0] store_b [MAT_DIM*MAT_DIM];
    logic [3:0]  row_cfg;
    logic [3:0]  col_cfg;

    result_t expected_results [$];

    int idle_pct = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int mismatch_count = 0;

    matrix_add_sub_mul_unit #(.DIM(MAT_DIM)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic int clamp_count(input logic [3:0] cnt);
        if (cnt == 4'd0)
        begin
            return 1;
        end
        if (int'(cnt) > MAT_DIM)
        begin
            return MAT_DIM;
        end
        return int'(cnt);
    endfunction

    function automatic result_t make_result(input logic [31:0] v, input int r, input int c,
                                            input logic [1:0] st, input logic lst);
        result_t res;
        res.elem_value = v;
        res.out_row    = 3'(r);
        res.out_col    = 3'(c);
        res.status     = st;
        res.last       = lst;
        return res;
    endfunction

    // Works out the result words that one accepted input word causes.
    task automatic predict_word(input item_t w);
        int          rows;
        int          cols;
        logic [31:0] acc;
        logic [63:0] prod;
        rows = clamp_count(row_cfg);
        cols = clamp_count(col_cfg);
        case (w.func)
            FUNC_WRITE_A: store_a[int'(w.row) * MAT_DIM + int'(w.col)] = w.value;
            FUNC_WRITE_B: store_b[int'(w.row) * MAT_DIM + int'(w.col)] = w.value;
            FUNC_ADD, FUNC_SUB, FUNC_MUL:
            begin
                if (w.func == FUNC_MUL && rows != cols)
                begin
                    expected_results.push_back(make_result('0, 0, 0, STATUS_SHAPE, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < rows; i++)
                    begin
                        for (int j = 0; j < cols; j++)
                        begin
                            if (w.func == FUNC_ADD)
                            begin
                                acc = store_a[i*MAT_DIM + j] + store_b[i*MAT_DIM + j];
                            end
                            else if (w.func == FUNC_SUB)
                            begin
                                acc = store_a[i*MAT_DIM + j] - store_b[i*MAT_DIM + j];
                            end
                            else
                            begin
                                acc = '0;
                                for (int k = 0; k < cols; k++)
                                begin
                                    prod = store_a[i*MAT_DIM + k] * store_b[k*MAT_DIM + j];
                                    acc = acc + prod[31:0];
                                end
                            end
                            expected_results.push_back(make_result(acc, i, j, STATUS_OK,
                                (i == rows - 1) && (j == cols - 1)));
                        end
                    end
                end
            end
            default: expected_results.push_back(make_result('0, 0, 0, STATUS_BAD_FUNC, 1'b1));
        endcase
    endtask

    // Compares each result word with the oldest expectation.
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                note_failure($sformatf(
                    "unexpected result word: val=%0d row=%0d col=%0d st=%0d last=%0d",
                    result.elem_value, result.out_row, result.out_col, result.status,
                    result.last));
            end
            else
            begin
                exp_res = expected_results.pop_front();
                results_checked++;
                if (result.elem_value !== exp_res.elem_value ||
                    result.out_row !== exp_res.out_row ||
                    result.out_col !== exp_res.out_col || result.status !== exp_res.status ||
                    result.last !== exp_res.last)
                begin
                    note_failure($sformatf({"result mismatch: expected val=%0d row=%0d col=%0d ",
                        "st=%0d last=%0d, got val=%0d row=%0d col=%0d st=%0d last=%0d"},
                        exp_res.elem_value, exp_res.out_row, exp_res.out_col, exp_res.status,
                        exp_res.last, result.elem_value, result.out_row, result.out_col,
                        result.status, result.last));
                end
            end
        end
    end

    // Start stays high after acceptance; the next call either presents a new word or drops it.
    task automatic send_word(input item_t w);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_word(w);
        items_sent++;
    endtask

    task automatic send_fields(input logic [2:0] f, input logic [2:0] r, input logic [2:0] c,
                               input logic [31:0] v);
        item_t w;
        w.func  = f;
        w.row   = r;
        w.col   = c;
        w.value = v;
        send_word(w);
    endtask

    // Drops start and waits until every expected word has arrived and the unit is idle.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0 && waited < WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        waited = 0;
        while (busy && waited < WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [3:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_ROW_COUNT)
        begin
            row_cfg = data;
        end
        else
        begin
            col_cfg = data;
        end
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input logic [3:0] rows, input logic [3:0] cols);
        settle();
        cfg_write(CFG_ROW_COUNT, rows);
        cfg_write(CFG_COL_COUNT, cols);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small counts to keep multiplies short, with zero and over-range now and then.
    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 4'($urandom_range(1, 4));
        end
        else if (r < 80)
        begin
            return 4'($urandom_range(5, 8));
        end
        else if (r < 90)
        begin
            return 4'd0;
        end
        return 4'($urandom_range(9, 15));
    endfunction

    // Every entry of both stores is written before any command reads it.
    task automatic test_load_stores();
        for (int r = 0; r < MAT_DIM; r++)
        begin
            for (int c = 0; c < MAT_DIM; c++)
            begin
                send_fields(FUNC_WRITE_A, 3'(r), 3'(c), pick_value());
                send_fields(FUNC_WRITE_B, 3'(r), 3'(c), pick_value());
            end
        end
    endtask

    // Wrapping sums, differences and products at (0,0), (0,1) and (7,7), using the counts left by reset.
    task automatic test_reset_shape();
        send_fields(FUNC_WRITE_A, 3'd0, 3'd0, 32'h7fff_ffff);
        send_fields(FUNC_WRITE_B, 3'd0, 3'd0, 32'h0000_0001);
        send_fields(FUNC_WRITE_A, 3'd0, 3'd1, 32'h8000_0000);
        send_fields(FUNC_WRITE_B, 3'd0, 3'd1, 32'h0000_0001);
        send_fields(FUNC_WRITE_A, 3'd7, 3'd7, 32'hffff_ffff);
        send_fields(FUNC_WRITE_B, 3'd7, 3'd7, 32'h8000_0000);
        send_fields(FUNC_ADD, 3'd0, 3'd0, 32'h0);
        send_fields(FUNC_SUB, 3'd7, 3'd7, 32'hffff_ffff);
        send_fields(FUNC_MUL, 3'd5, 3'd2, 32'h8000_0000);
    endtask

    // A count of zero acts as one and a count above the store size acts as the size.
    task automatic test_count_clamp();
        set_shape(4'd0, 4'd15);
        send_fields(FUNC_ADD, 3'd1, 3'd6, $urandom);
        send_fields(FUNC_MUL, 3'd0, 3'd0, $urandom);
        set_shape(4'd15, 4'd0);
        send_fields(FUNC_SUB, 3'd7, 3'd0, $urandom);
        set_shape(4'd0, 4'd0);
        send_fields(FUNC_MUL, 3'd2, 3'd3, $urandom);
        set_shape(4'd9, 4'd9);
        send_fields(FUNC_ADD, 3'd4, 3'd4, $urandom);
        set_shape(4'd3, 4'd2);
        send_fields(FUNC_MUL, 3'd7, 3'd7, $urandom);
    endtask

    task automatic test_bad_func();
        set_shape(4'd2, 4'd2);
        send_fields(FUNC_INVALID_LO, 3'd7, 3'd7, 32'hffff_ffff);
        send_fields(FUNC_INVALID_MID, 3'd0, 3'd0, 32'h0);
        send_fields(FUNC_INVALID_HI, 3'($urandom), 3'($urandom), $urandom);
        send_fields(FUNC_MUL, 3'd7, 3'd7, 32'h7fff_ffff);
    endtask

    task automatic test_random();
        logic [3:0] rows;
        logic [3:0] cols;
        int         r;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            rows = pick_count();
            cols = ($urandom_range(0, 99) < 40) ? rows : pick_count();
            set_shape(rows, cols);
            case (blk % 3)
                0: idle_pct = 0;
                1: idle_pct = 54;
                default: idle_pct = 17;
            endcase
            for (int n = 0; n < WORDS_PER_BLOCK; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    send_fields(3'($urandom_range(FUNC_WRITE_A, FUNC_WRITE_B)), 3'($urandom),
                                3'($urandom), pick_value());
                end
                else if (r < 88)
                begin
                    send_fields(3'($urandom_range(FUNC_ADD, FUNC_MUL)), 3'($urandom),
                                3'($urandom), $urandom);
                end
                else
                begin
                    send_fields(3'($urandom_range(FUNC_INVALID_LO, FUNC_INVALID_HI)),
                                3'($urandom), 3'($urandom), $urandom);
                end
            end
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 4'd0;
        row_cfg   = COUNT_RESET;
        col_cfg   = COUNT_RESET;
        for (int i = 0; i < MAT_DIM*MAT_DIM; i++)
        begin
            store_a[i] = '0;
            store_b[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_stores();
        test_reset_shape();
        test_count_clamp();
        test_bad_func();
        test_random();
        settle();

        if (expected_results.size() != 0)
        begin
            note_failure($sformatf("%0d expected result words never arrived",
                expected_results.size()));
        end
        $display("Sent %0d input words over %0d random blocks and checked %0d result words,",
                 items_sent, RANDOM_BLOCKS, results_checked);
        $display("with %0d count writes and %0d failures.", cfg_writes, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out waiting on the unit.");
        $display("Regression FAIL");
        $finish;
    end

endmodule
